/* rtl/unsharp_mask_sharpen_defines.svh */
// assertion macros of the sharpener top level
`ifndef UNSHARP_MASK_SHARPEN_DEFINES_SVH
`define UNSHARP_MASK_SHARPEN_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define UMS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define UMS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ums_pkg.sv */
// types, codes and helpers of the unsharp mask sharpener
`default_nettype none

package ums_pkg;

  // kernel coefficient layout
  localparam int COEF_SIDE  = 7;
  localparam int COEF_COUNT = 49;

  // saturation limit of a q8.8 result
  localparam logic [15:0] PIX_MAX_Q = 16'd65280;

  // item modes
  localparam logic [1:0] MODE_COEF  = 2'd0;
  localparam logic [1:0] MODE_PIXEL = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;

  // register indexes
  localparam logic [2:0] REG_RADIUS = 3'd0;
  localparam logic [2:0] REG_WIDTH  = 3'd1;
  localparam logic [2:0] REG_HEIGHT = 3'd2;
  localparam logic [2:0] REG_THRESH = 3'd3;
  localparam logic [2:0] REG_GAIN   = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  coef_index;
    logic [15:0] coef_value;
    logic [7:0]  pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] sharp_value;
    logic        frame_last;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  addr;
    logic [15:0] wdata;
  } cfg_item_t;

  // controls broadcast to every tap cell
  typedef struct packed {
    logic        shift;
    logic        mul;
    logic [2:0]  side;
    logic [2:0]  rd_row;
    logic        coef_we;
    logic [2:0]  wr_row;
    logic [2:0]  wr_col;
    logic [15:0] wr_value;
  } cell_ctrl_t;

  // kernel row of a coefficient index, idx / 7 by reciprocal
  function automatic logic [2:0] coef_row(input logic [5:0] idx);
    logic [11:0] t;
    t = {6'd0, idx} * 12'd37;
    return t[10:8];
  endfunction

endpackage

`default_nettype wire

/* rtl/ums_chan_if.sv */
// handshake channels of the sharpener: pixel items in, results out, register writes
`default_nettype none

interface ums_in_if;
  logic               valid;
  logic               ready;
  ums_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ums_out_if;
  logic               valid;
  logic               ready;
  ums_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ums_cfg_if;
  logic               valid;
  logic               ready;
  ums_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/unsharp_mask_sharpen.sv */
// Unsharp mask sharpener, top level.
// Channels: in_i takes items (load a kernel coefficient, a pixel in raster order,
// or flush one pending result), out_o delivers sharpened q8.8 pixels with a
// frame-end flag, cfg_i writes the five registers by index.
// A pixel is written to an eight-row line store; once enough of the frame has
// arrived it produces the result lying radius rows and radius columns behind.
// After the last pixel, flush items drain the remaining results one per item.
// For an item that yields a result, with R the kernel radius, the window is
// gathered through the single read port of the line store, one pixel per cycle,
// and a row of tap cells, 2R+1 of them in use, multiplies and sums one kernel
// row at a time, before the result goes to the output register. One item is in
// work at once. A register write recomputes the output position with a serial
// divider, during which no item is taken.
// The output register holds a result while the receiver stalls; the block stops
// before loading the next result until it is taken.
// Reset clears coefficients, counters and registers to defaults; line store
// contents are not cleared and need no clearing pass.
`default_nettype none
`include "unsharp_mask_sharpen_defines.svh"

module unsharp_mask_sharpen #(
  parameter int unsigned MAX_RADIUS = 3,
  parameter int unsigned MAX_WIDTH  = 2048
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ums_in_if.sink    in_i,
  ums_out_if.source out_o,
  ums_cfg_if.sink   cfg_i
);

  localparam int unsigned RMAX  = (MAX_RADIUS < 3) ? MAX_RADIUS : 3;
  localparam int unsigned NCELL = 2 * RMAX + 1;
  localparam int unsigned CIW   = $clog2(NCELL);
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned WW    = CW + 1;
  localparam int unsigned WHW   = WW + 12;
  localparam int unsigned SW    = $clog2(2 * MAX_RADIUS + 2);
  localparam int unsigned DEPTH = (1 << SW) << CW;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PXA  = 4'd1;
  localparam logic [3:0] ST_PXB  = 4'd2;
  localparam logic [3:0] ST_RD   = 4'd3;
  localparam logic [3:0] ST_WT   = 4'd4;
  localparam logic [3:0] ST_MUL  = 4'd5;
  localparam logic [3:0] ST_ADD  = 4'd6;
  localparam logic [3:0] ST_FIN1 = 4'd7;
  localparam logic [3:0] ST_FIN2 = 4'd8;
  localparam logic [3:0] ST_FIN3 = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;
  localparam logic [3:0] ST_DIV  = 4'd11;

  // registers
  logic [1:0]         cfg_rad_q;
  logic [11:0]        cfg_w_q;
  logic [11:0]        cfg_h_q;
  logic signed [15:0] cfg_thr_q;
  logic [11:0]        cfg_gain_q;

  // control
  logic [3:0]     state_q;
  ums_pkg::in_item_t item_q;
  logic [CW-1:0]  in_col_q;
  logic [10:0]    in_row_q;
  logic           last_pix_q;
  logic [WHW-1:0] oc_q;
  logic [10:0]    orow_q;
  logic [CW-1:0]  ocol_q;
  logic           pending_q;
  logic           div_req_q;
  logic [2:0]     a_q;
  logic [2:0]     b_q;
  logic           rd_vld_q;
  logic           out_valid_q;

  // datapath
  logic [WHW-1:0]     wh_q;
  logic [WHW-1:0]     lag_q;
  logic [WHW-1:0]     rowmul_q;
  logic [CW-1:0]      col_cl_q;
  logic [29:0]        acc_q;
  logic [7:0]         center_q;
  logic signed [23:0] d_q;
  logic               sharp_q;
  logic signed [36:0] prod_q;
  logic [15:0]        res_q;
  logic [7:0]         rd_data_q;
  ums_pkg::out_item_t out_data_q;
  logic [7:0]         line_mem [DEPTH];

  // effective register values
  logic [1:0]    rad;
  logic [2:0]    side;
  logic [WW-1:0] w_eff;
  logic [WW-1:0] w_m1;
  logic [WW-1:0] hr;
  logic [11:0]   h_eff;
  logic [11:0]   h_m1;

  always_comb begin
    rad = (cfg_rad_q > 2'(RMAX)) ? 2'(RMAX) : cfg_rad_q;
    side = {rad, 1'b1};
    if (cfg_w_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_w_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_w_q);
    end
    w_m1 = w_eff - WW'(1);
    hr = (WW'(rad) < w_m1) ? WW'(rad) : w_m1;
    if (cfg_h_q == '0) begin
      h_eff = 12'd1;
    end else if (cfg_h_q > 12'd2048) begin
      h_eff = 12'd2048;
    end else begin
      h_eff = cfg_h_q;
    end
    h_m1 = h_eff - 12'd1;
  end

  // handshakes
  logic in_acc;
  logic cfg_acc;
  logic out_load;
  logic out_last;

  assign in_i.ready  = (state_q == ST_IDLE) && !div_req_q && !cfg_i.valid;
  assign cfg_i.ready = (state_q == ST_IDLE) && !div_req_q;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);
  assign out_last    = (oc_q + WHW'(1)) >= wh_q;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // coefficient load routing
  logic [2:0] ld_row;
  logic [5:0] ld_col;
  logic       ld_we;

  always_comb begin
    ld_row = ums_pkg::coef_row(in_i.data.coef_index);
    ld_col = in_i.data.coef_index - {3'd0, ld_row} * 6'd7;
    ld_we  = in_acc && (in_i.data.mode == ums_pkg::MODE_COEF) &&
             (32'(in_i.data.coef_index) < ums_pkg::COEF_COUNT);
  end

  // input position clamped into the frame
  logic [CW-1:0] col_cl;
  logic [10:0]   row_cl;
  logic [WHW-1:0] k_pos;
  logic          emit;

  always_comb begin
    col_cl = (WW'(in_col_q) > w_m1) ? w_m1[CW-1:0] : in_col_q;
    row_cl = ({1'b0, in_row_q} > h_m1) ? h_m1[10:0] : in_row_q;
    k_pos  = rowmul_q + WHW'(col_cl_q);
    emit   = (k_pos >= lag_q) && ((oc_q + lag_q) <= k_pos) && (oc_q < wh_q);
  end

  // window read address with replicated borders
  logic [10:0]        r_cl;
  logic signed [12:0] rr_s;
  logic signed [CW+1:0] cc_s;
  logic [10:0]        rr;
  logic [CW-1:0]      cc;

  always_comb begin
    r_cl = ({1'b0, orow_q} > h_m1) ? h_m1[10:0] : orow_q;
    rr_s = $signed({2'b00, r_cl}) - $signed({11'd0, rad}) + $signed({10'd0, a_q});
    cc_s = $signed({2'b00, ocol_q}) - $signed({CW'(0), rad}) +
           $signed({(CW - 1)'(0), b_q});
    if (rr_s < 0) begin
      rr = '0;
    end else if (rr_s > $signed({1'b0, h_m1})) begin
      rr = h_m1[10:0];
    end else begin
      rr = rr_s[10:0];
    end
    if (cc_s < 0) begin
      cc = '0;
    end else if (cc_s > $signed({1'b0, w_m1})) begin
      cc = w_m1[CW-1:0];
    end else begin
      cc = cc_s[CW-1:0];
    end
  end

  // tap cell chain
  ums_pkg::cell_ctrl_t cell_ctrl;
  logic [7:0]  cell_pix  [NCELL];
  logic [23:0] cell_prod [NCELL];

  always_comb begin
    cell_ctrl.shift    = rd_vld_q;
    cell_ctrl.mul      = state_q == ST_MUL;
    cell_ctrl.side     = side;
    cell_ctrl.rd_row   = side - 3'd1 - a_q;
    cell_ctrl.coef_we  = ld_we;
    cell_ctrl.wr_row   = ld_row;
    cell_ctrl.wr_col   = ld_col[2:0];
    cell_ctrl.wr_value = in_i.data.coef_value;
  end

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    logic [7:0] pix_in;
    if (j == 0) begin : g_head
      assign pix_in = rd_data_q;
    end else begin : g_link
      assign pix_in = cell_pix[j-1];
    end
    ums_tap_cell #(
      .POS (j)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .pix_i  (pix_in),
      .pix_o  (cell_pix[j]),
      .prod_o (cell_prod[j])
    );
  end

  // sum of one kernel row
  logic [26:0] row_sum;
  always_comb begin
    row_sum = '0;
    for (int j = 0; j < NCELL; j++) begin
      row_sum = row_sum + 27'(cell_prod[j]);
    end
  end

  // output position recompute after register writes
  logic           div_start;
  logic           div_busy;
  logic [WHW-1:0] div_quo;
  logic [WW-1:0]  div_rem;

  assign div_start = (state_q == ST_IDLE) && div_req_q;

  ums_divider #(
    .NUM_W (WHW),
    .DEN_W (WW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (oc_q),
    .den_i   (w_eff),
    .busy_o  (div_busy),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // line store
  always_ff @(posedge clk_i) begin
    if (state_q == ST_PXA) begin
      line_mem[{row_cl[SW-1:0], col_cl}] <= item_q.pixel_value;
    end
    rd_data_q <= line_mem[{rr[SW-1:0], cc}];
  end

  // result arithmetic
  logic [21:0]        smooth;
  logic [15:0]        p256;
  logic signed [23:0] d_c;
  logic signed [28:0] rs;
  logic signed [29:0] v_c;

  always_comb begin
    smooth = 22'((acc_q + 30'd128) >> 8);
    p256   = {center_q, 8'd0};
    d_c    = $signed({8'd0, p256}) - $signed({2'b00, smooth});
    rs     = 29'((prod_q + 37'sd128) >>> 8);
    v_c    = $signed({14'd0, p256}) + 30'(rs);
  end

  // registers written through the configuration channel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_rad_q  <= 2'd1;
      cfg_w_q    <= 12'd640;
      cfg_h_q    <= 12'd480;
      cfg_thr_q  <= '0;
      cfg_gain_q <= 12'd256;
    end else if (cfg_acc) begin
      case (cfg_i.data.addr)
        ums_pkg::REG_RADIUS: cfg_rad_q  <= cfg_i.data.wdata[1:0];
        ums_pkg::REG_WIDTH:  cfg_w_q    <= cfg_i.data.wdata[11:0];
        ums_pkg::REG_HEIGHT: cfg_h_q    <= cfg_i.data.wdata[11:0];
        ums_pkg::REG_THRESH: cfg_thr_q  <= cfg_i.data.wdata;
        ums_pkg::REG_GAIN:   cfg_gain_q <= cfg_i.data.wdata[11:0];
        default: ;
      endcase
    end
  end

  // frame constants follow the registers
  always_ff @(posedge clk_i) begin
    wh_q  <= WHW'(w_eff) * WHW'(h_eff);
    lag_q <= WHW'(rad) * WHW'(w_eff) + WHW'(hr);
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_col_q    <= '0;
      in_row_q    <= '0;
      last_pix_q  <= 1'b0;
      oc_q        <= '0;
      orow_q      <= '0;
      ocol_q      <= '0;
      pending_q   <= 1'b0;
      div_req_q   <= 1'b0;
      a_q         <= '0;
      b_q         <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= state_q == ST_RD;
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_acc) begin
        div_req_q <= 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          if (div_req_q) begin
            div_req_q <= 1'b0;
            state_q   <= ST_DIV;
          end else if (in_acc) begin
            case (in_i.data.mode)
              ums_pkg::MODE_PIXEL: begin
                if (pending_q) begin
                  pending_q <= 1'b0;
                  oc_q      <= '0;
                  orow_q    <= '0;
                  ocol_q    <= '0;
                end
                state_q <= ST_PXA;
              end
              ums_pkg::MODE_FLUSH: begin
                if (pending_q && (oc_q < wh_q)) begin
                  a_q     <= '0;
                  b_q     <= '0;
                  state_q <= ST_RD;
                end
              end
              default: ;
            endcase
          end
        end
        ST_PXA: begin
          if (WW'(col_cl) + WW'(1) >= w_eff) begin
            in_col_q <= '0;
            if ({1'b0, row_cl} + 12'd1 >= h_eff) begin
              in_row_q   <= '0;
              last_pix_q <= 1'b1;
            end else begin
              in_row_q   <= row_cl + 11'd1;
              last_pix_q <= 1'b0;
            end
          end else begin
            in_col_q   <= col_cl + CW'(1);
            in_row_q   <= row_cl;
            last_pix_q <= 1'b0;
          end
          state_q <= ST_PXB;
        end
        ST_PXB: begin
          if (last_pix_q) begin
            pending_q <= 1'b1;
          end
          if (emit) begin
            a_q     <= '0;
            b_q     <= '0;
            state_q <= ST_RD;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_RD: begin
          if (b_q == side - 3'd1) begin
            state_q <= ST_WT;
          end else begin
            b_q <= b_q + 3'd1;
          end
        end
        ST_WT: begin
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          if (a_q == side - 3'd1) begin
            state_q <= ST_FIN1;
          end else begin
            a_q     <= a_q + 3'd1;
            b_q     <= '0;
            state_q <= ST_RD;
          end
        end
        ST_FIN1: state_q <= ST_FIN2;
        ST_FIN2: state_q <= ST_FIN3;
        ST_FIN3: state_q <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            if (out_last) begin
              oc_q      <= '0;
              orow_q    <= '0;
              ocol_q    <= '0;
              pending_q <= 1'b0;
            end else begin
              oc_q <= oc_q + WHW'(1);
              if (WW'(ocol_q) + WW'(1) >= w_eff) begin
                ocol_q <= '0;
                orow_q <= orow_q + 11'd1;
              end else begin
                ocol_q <= ocol_q + CW'(1);
              end
            end
            state_q <= ST_IDLE;
          end
        end
        ST_DIV: begin
          if (!div_busy) begin
            orow_q  <= div_quo[10:0];
            ocol_q  <= div_rem[CW-1:0];
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_i.data;
    end
    if (state_q == ST_PXA) begin
      rowmul_q <= WHW'(row_cl) * WHW'(w_eff);
      col_cl_q <= col_cl;
    end
    if (state_q == ST_IDLE || state_q == ST_PXB) begin
      acc_q <= '0;
    end else if (state_q == ST_ADD) begin
      acc_q <= acc_q + 30'(row_sum);
    end
    if (state_q == ST_MUL && a_q == {1'b0, rad}) begin
      center_q <= cell_pix[CIW'(rad)];
    end
    if (state_q == ST_FIN1) begin
      d_q     <= d_c;
      sharp_q <= d_c > 24'(cfg_thr_q);
    end
    if (state_q == ST_FIN2) begin
      prod_q <= 37'(d_q) * $signed({25'd0, cfg_gain_q});
    end
    if (state_q == ST_FIN3) begin
      if (!sharp_q) begin
        res_q <= p256;
      end else if (v_c < 0) begin
        res_q <= '0;
      end else if (v_c > $signed({14'd0, ums_pkg::PIX_MAX_Q})) begin
        res_q <= ums_pkg::PIX_MAX_Q;
      end else begin
        res_q <= v_c[15:0];
      end
    end
    if (out_load) begin
      out_data_q.sharp_value <= res_q;
      out_data_q.frame_last  <= out_last;
    end
  end

  // checks on the sequencer
  `UMS_ASSERT_NOW(a_emit_in_frame, out_load, oc_q < wh_q, "result beyond frame end")
  `UMS_ASSERT_NEXT(a_last_clears, out_load && out_last, (oc_q == '0) && !pending_q, "frame end kept count")
  `UMS_ASSERT_NOW(a_read_window, rd_vld_q, (state_q == ST_RD) || (state_q == ST_WT), "stray line read")

endmodule

`default_nettype wire

/* rtl/ums_tap_cell.sv */
// one kernel column cell: coefficient column, pixel tap and product register
`default_nettype none

module ums_tap_cell #(
  parameter int unsigned POS = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ums_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]          pix_i,
  output logic [7:0]          pix_o,
  output logic [23:0]         prod_o
);

  logic [15:0] coef_q [ums_pkg::COEF_SIDE];
  logic [7:0]  pix_q;
  logic [23:0] prod_q;

  // coefficient column of this cell, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ums_pkg::COEF_SIDE; i++) begin
        coef_q[i] <= '0;
      end
    end else if (ctrl_i.coef_we && (ctrl_i.wr_col == 3'(POS))) begin
      coef_q[ctrl_i.wr_row] <= ctrl_i.wr_value;
    end
  end

  // pixel tap moves to the neighbor, product of the selected kernel row
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      pix_q <= pix_i;
    end
    if (ctrl_i.mul) begin
      if (3'(POS) < ctrl_i.side) begin
        prod_q <= {8'd0, coef_q[ctrl_i.rd_row]} * {16'd0, pix_q};
      end else begin
        prod_q <= '0;
      end
    end
  end

  assign pix_o  = pix_q;
  assign prod_o = prod_q;

endmodule

`default_nettype wire

/* rtl/ums_divider.sv */
// restoring divider, one quotient bit per cycle
`default_nettype none

module ums_divider #(
  parameter int unsigned NUM_W = 24,
  parameter int unsigned DEN_W = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic             fits;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    fits  = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(NUM_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      if (fits) begin
        rem_q <= DEN_W'(trial - {1'b0, den_q});
      end else begin
        rem_q <= trial[DEN_W-1:0];
      end
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// self-checking testbench of the unsharp mask sharpener with its own pixel predictor
`timescale 1ns / 1ps

module testbench;
  import ums_pkg::*;

  localparam int SLOT_ROWS = 8;
  localparam int LINE_LEN  = 2048;

  logic clk;
  logic rst_n;

  ums_in_if  in_ch ();
  ums_out_if out_ch ();
  ums_cfg_if cfg_ch ();

  unsharp_mask_sharpen dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  // predictor state
  logic [7:0]  line_mem [SLOT_ROWS*LINE_LEN];
  logic [15:0] coef_mem [COEF_COUNT];
  int          in_col, in_row, out_cnt;
  bit          frame_pend;
  logic [1:0]  reg_rad;
  logic [11:0] reg_w, reg_h, reg_gain;
  logic [15:0] reg_thr;

  out_item_t   sharp_q[$];
  int          errors;
  int          src_pct, snk_pct;
  int          pixels_sent;

  // typed expectation riding along with a table item
  bit          tab_flag;
  out_item_t   tab_val;

  typedef struct {
    logic [1:0]  mode;
    logic [5:0]  idx;
    logic [15:0] val;
    logic [7:0]  pix;
    bit          typed;
    logic [15:0] exp_sharp;
    logic        exp_last;
  } dir_row_t;

  dir_row_t dir_tab [16];

  function automatic int eff_w();
    return (reg_w == 0) ? 1 : ((reg_w > LINE_LEN) ? LINE_LEN : int'(reg_w));
  endfunction

  function automatic int eff_h();
    return (reg_h == 0) ? 1 : ((reg_h > 2048) ? 2048 : int'(reg_h));
  endfunction

  function automatic int clamp_rd(int row, int col, int w, int h);
    if (row < 0) row = 0;
    if (row > h - 1) row = h - 1;
    if (col < 0) col = 0;
    if (col > w - 1) col = w - 1;
    return line_mem[(row % SLOT_ROWS) * LINE_LEN + (col % LINE_LEN)];
  endfunction

  // sharpen the pixel at the output position and advance it
  function automatic out_item_t sharpen_next(int w, int h);
    int        rad, side, r, c, a, b;
    longint    acc, s, p, d, v, thr;
    out_item_t res;
    rad  = reg_rad;
    side = 2 * rad + 1;
    r    = out_cnt / w;
    c    = out_cnt % w;
    acc  = 0;
    if (r > h - 1) r = h - 1;
    // flipped kernel over a replicated-border window
    for (a = 0; a < side; a++)
      for (b = 0; b < side; b++)
        acc += longint'(coef_mem[(side - 1 - a) * COEF_SIDE + (side - 1 - b)])
               * clamp_rd(r - rad + a, c - rad + b, w, h);
    s   = (acc + 128) >> 8;
    p   = longint'(clamp_rd(r, c, w, h)) * 256;
    d   = p - s;
    thr = longint'($signed(reg_thr));
    v   = p;
    if (d > thr) v = p + ((d * longint'(reg_gain) + 128) >>> 8);
    if (v < 0) v = 0;
    if (v > PIX_MAX_Q) v = PIX_MAX_Q;
    out_cnt++;
    res.sharp_value = v[15:0];
    res.frame_last  = 1'b0;
    if (out_cnt >= w * h) begin
      res.frame_last = 1'b1;
      out_cnt        = 0;
      frame_pend     = 0;
    end
    return res;
  endfunction

  // state update for one accepted item, returns 1 when it yields a result
  function automatic bit predict_sharp(in_item_t it, output out_item_t res);
    int w, h, rad, hr, lag, row, col, k;
    bit n;
    w   = eff_w();
    h   = eff_h();
    res = '0;
    n   = 0;
    case (it.mode)
      MODE_COEF: begin
        if (it.coef_index < COEF_COUNT) coef_mem[it.coef_index] = it.coef_value;
      end
      MODE_PIXEL: begin
        rad = reg_rad;
        hr  = (rad < w - 1) ? rad : w - 1;
        lag = rad * w + hr;
        row = in_row;
        col = in_col;
        if (frame_pend) begin
          frame_pend = 0;
          out_cnt    = 0;
        end
        if (col > w - 1) col = w - 1;
        if (row > h - 1) row = h - 1;
        line_mem[(row % SLOT_ROWS) * LINE_LEN + (col % LINE_LEN)] = it.pixel_value;
        k = row * w + col;
        if (k >= lag && out_cnt + lag <= k && out_cnt < w * h) begin
          res = sharpen_next(w, h);
          n   = 1;
        end
        if (col + 1 >= w) begin
          in_col = 0;
          if (row + 1 >= h) begin
            in_row     = 0;
            frame_pend = (!n || !res.frame_last);
          end else begin
            in_row = row + 1;
          end
        end else begin
          in_col = col + 1;
          in_row = row;
        end
      end
      MODE_FLUSH: begin
        if (frame_pend && out_cnt < w * h) begin
          res = sharpen_next(w, h);
          n   = 1;
        end
      end
      default: ;
    endcase
    return n;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_pct);
  end

  // predict on input acceptance, check on output acceptance
  always @(posedge clk) begin
    out_item_t exp_r, got, res;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (sharp_q.size() == 0) begin
          $error("unexpected result sharp_value %0d frame_last %0d",
                 got.sharp_value, got.frame_last);
          errors++;
        end else begin
          exp_r = sharp_q.pop_front();
          if (got.sharp_value !== exp_r.sharp_value) begin
            $error("sharp_value expected %0d got %0d", exp_r.sharp_value, got.sharp_value);
            errors++;
          end
          if (got.frame_last !== exp_r.frame_last) begin
            $error("frame_last expected %0d got %0d", exp_r.frame_last, got.frame_last);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (predict_sharp(in_ch.data, res)) sharp_q.push_back(tab_flag ? tab_val : res);
      end
    end
  end

  task automatic send_item(in_item_t it, bit typed, out_item_t tv);
    while ($urandom_range(99) < src_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    tab_flag    <= typed;
    tab_val     <= tv;
    do @(posedge clk); while (!in_ch.ready);
    if (it.mode == MODE_PIXEL) pixels_sent++;
  endtask

  task automatic send_plain(logic [1:0] mode, logic [5:0] idx, logic [15:0] val,
                            logic [7:0] pix);
    in_item_t it;
    it.mode        = mode;
    it.coef_index  = idx;
    it.coef_value  = val;
    it.pixel_value = pix;
    send_item(it, 0, '0);
  endtask

  task automatic wait_empty();
    in_ch.valid <= 1'b0;
    while (sharp_q.size() != 0) @(posedge clk);
  endtask

  // registers change only once the block has gone quiet
  task automatic set_regs(int rad, int w, int h, int thr, int gain);
    cfg_item_t ci [5];
    int        i;
    wait_empty();
    repeat (100) @(posedge clk);
    ci[0] = '{addr: REG_RADIUS, wdata: 16'(rad)};
    ci[1] = '{addr: REG_WIDTH,  wdata: 16'(w)};
    ci[2] = '{addr: REG_HEIGHT, wdata: 16'(h)};
    ci[3] = '{addr: REG_THRESH, wdata: 16'(thr)};
    ci[4] = '{addr: REG_GAIN,   wdata: 16'(gain)};
    for (i = 0; i < 5; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.data  <= ci[i];
      do @(posedge clk); while (!cfg_ch.ready);
      case (ci[i].addr)
        REG_RADIUS: reg_rad  = ci[i].wdata[1:0];
        REG_WIDTH:  reg_w    = ci[i].wdata[11:0];
        REG_HEIGHT: reg_h    = ci[i].wdata[11:0];
        REG_THRESH: reg_thr  = ci[i].wdata;
        REG_GAIN:   reg_gain = ci[i].wdata[11:0];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // one frame: optional kernel load, pixels with noise, then flushes
  task automatic run_frame(bit may_drop);
    int w, h, rad, side, lag, pend, i, a, b, cap, n;
    w    = eff_w();
    h    = eff_h();
    rad  = reg_rad;
    side = 2 * rad + 1;
    n    = w * h;
    lag  = rad * w + ((rad < w - 1) ? rad : w - 1);
    if ($urandom_range(1) == 0) begin
      cap = ($urandom_range(3) == 0) ? 65535 : (2 * 65536) / (side * side);
      if (cap > 65535) cap = 65535;
      for (a = 0; a < side; a++)
        for (b = 0; b < side; b++)
          send_plain(MODE_COEF, 6'(a * COEF_SIDE + b), 16'($urandom_range(cap)), 8'd0);
    end
    for (i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0)
        send_plain(2'($urandom_range(3)), 6'($urandom_range(63)), 16'($urandom),
                   8'($urandom));
      if (i == n / 2 && $urandom_range(7) == 0) wait_empty();
      case ($urandom_range(9))
        0:       send_plain(MODE_PIXEL, 6'($urandom), 16'($urandom), 8'd0);
        1:       send_plain(MODE_PIXEL, 6'($urandom), 16'($urandom), 8'd255);
        default: send_plain(MODE_PIXEL, 6'($urandom), 16'($urandom), 8'($urandom));
      endcase
    end
    pend = (lag < n) ? lag : n;
    if (may_drop && pend > 0 && $urandom_range(5) == 0) pend = $urandom_range(pend - 1);
    for (i = 0; i < pend; i++)
      send_plain(MODE_FLUSH, 6'($urandom), 16'($urandom), 8'($urandom));
    if ($urandom_range(3) == 0)
      send_plain(MODE_FLUSH, 6'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic random_phase(int quota);
    int thr, gain, frames, f;
    while (pixels_sent < quota) begin
      case ($urandom_range(3))
        0:       thr = -32768;
        1:       thr = 32767;
        2:       thr = $urandom_range(2047) - 1024;
        default: thr = $urandom_range(65535);
      endcase
      case ($urandom_range(3))
        0:       gain = 0;
        1:       gain = 4095;
        default: gain = $urandom_range(4095);
      endcase
      set_regs($urandom_range(3), ($urandom_range(4) == 0) ? 1 : $urandom_range(16, 1),
               ($urandom_range(4) == 0) ? 1 : $urandom_range(8, 1), thr, gain);
      frames = $urandom_range(3, 1);
      for (f = 0; f < frames; f++) run_frame(f != frames - 1);
    end
  endtask

  // time limit
  initial begin
    #30ms;
    $display("FAILURE");
    $finish;
  end

  // main sequence
  initial begin
    in_item_t it;
    out_item_t tv;
    int i;
    errors      = 0;
    pixels_sent = 0;
    src_pct     = 0;
    snk_pct     = 0;
    in_col      = 0;
    in_row      = 0;
    out_cnt     = 0;
    frame_pend  = 0;
    reg_rad     = 2'd1;
    reg_w       = 12'd640;
    reg_h       = 12'd480;
    reg_thr     = 16'd0;
    reg_gain    = 12'd256;
    tab_flag    = 0;
    tab_val     = '0;
    foreach (coef_mem[i]) coef_mem[i] = '0;
    foreach (line_mem[i]) line_mem[i] = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b0;
    rst_n        = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single-pixel frames, zero kernel first so the result is pixel doubled
    dir_tab = '{
      '{MODE_PIXEL, 6'd0,  16'd0,     8'd255, 1, 16'd65280, 1'b1},
      '{MODE_PIXEL, 6'd0,  16'd0,     8'd0,   1, 16'd0,     1'b1},
      '{MODE_PIXEL, 6'd0,  16'd0,     8'd100, 1, 16'd51200, 1'b1},
      '{MODE_PIXEL, 6'd63, 16'hFFFF,  8'd1,   1, 16'd512,   1'b1},
      '{2'd3,       6'd0,  16'hFFFF,  8'd255, 0, 16'd0,     1'b0},
      '{MODE_FLUSH, 6'd0,  16'd0,     8'd0,   0, 16'd0,     1'b0},
      '{MODE_COEF,  6'd63, 16'hFFFF,  8'd0,   0, 16'd0,     1'b0},
      '{MODE_COEF,  6'd49, 16'h1234,  8'd0,   0, 16'd0,     1'b0},
      '{MODE_PIXEL, 6'd0,  16'd0,     8'd128, 0, 16'd0,     1'b0},
      '{MODE_COEF,  6'd0,  16'hFFFF,  8'd0,   0, 16'd0,     1'b0},
      '{MODE_COEF,  6'd48, 16'hFFFF,  8'd0,   0, 16'd0,     1'b0},
      '{MODE_PIXEL, 6'd0,  16'd0,     8'd255, 0, 16'd0,     1'b0},
      '{MODE_PIXEL, 6'd0,  16'd0,     8'd0,   0, 16'd0,     1'b0},
      '{MODE_COEF,  6'd0,  16'h0001,  8'd0,   0, 16'd0,     1'b0},
      '{MODE_PIXEL, 6'd0,  16'd0,     8'd77,  0, 16'd0,     1'b0},
      '{MODE_FLUSH, 6'd0,  16'd0,     8'd0,   0, 16'd0,     1'b0}
    };
    set_regs(0, 1, 1, 0, 256);
    for (i = 0; i < 16; i++) begin
      it.mode         = dir_tab[i].mode;
      it.coef_index   = dir_tab[i].idx;
      it.coef_value   = dir_tab[i].val;
      it.pixel_value  = dir_tab[i].pix;
      tv.sharp_value  = dir_tab[i].exp_sharp;
      tv.frame_last   = dir_tab[i].exp_last;
      send_item(it, dir_tab[i].typed, tv);
    end

    // random stages with different stall mixes
    src_pct = 23;
    snk_pct = 58;
    random_phase(500);
    src_pct = 58;
    snk_pct = 23;
    random_phase(1000);
    src_pct = 0;
    snk_pct = 0;
    random_phase(1500);

    // widest row, tallest column, then the widest radius on a single pixel
    set_regs(0, 2048, 1, 0, 4095);
    run_frame(0);
    set_regs(0, 1, 2048, -32768, 128);
    run_frame(0);
    set_regs(3, 1, 1, 32767, 0);
    run_frame(0);

    wait_empty();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
